FILE: rtl/core/cfsa_pkg.sv
// cfsa_pkg: types and constants for the cyclic free-server allocator.
// No dependencies.
package cfsa_pkg;
  localparam int CNT_BITS = 32;
  localparam int CFG_BITS = 11;

  typedef struct packed {
    logic [31:0] arrival_time;
    logic [31:0] service_time;
  } cfsa_in_t;

  typedef struct packed {
    logic        dropped;
    logic [9:0]  server;
    logic [31:0] server_count;
    logic [31:0] max_count;
  } cfsa_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_UPDATE
  } cfsa_state_t;

  localparam logic [0:0] REG_ACTIVE_SERVERS = 1'b0;
endpackage

FILE: rtl/core/cyclic_free_server_allocator.sv
// cyclic_free_server_allocator: round-robin next-free-server assignment.
// Depends on cfsa_pkg.
//
//  channel | ports                    | handshake
//  in      | in_start/in_busy/in_word | accepted when start & !busy
//  out     | out_valid/out_word       | one-cycle strobe, no stall
//  cfg     | psel/penable/pwrite/...  | APB, pready always high
//
// Each server inspected takes a memory read (ST_WAIT) and then a compare
// (ST_SCAN). A request assigned at the k-th server inspected passes through
// ST_WAIT and ST_SCAN k times, then ST_UPDATE, and its word is shown once the
// block is back in ST_IDLE. A dropped request scans all n active servers.
// After reset and after each write of active_servers a clearing pass over all
// MAX_SERVERS entries runs, during which in_busy is high.
// The receiver cannot stall: each result is shown for one cycle only.
module cyclic_free_server_allocator #(
  parameter int MAX_SERVERS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_start,
  output logic                 in_busy,
  input  cfsa_pkg::cfsa_in_t   in_word,
  output logic                 out_valid,
  output cfsa_pkg::cfsa_out_t  out_word,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [0:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cfsa_pkg::*;

  localparam int IW = $clog2(MAX_SERVERS);
  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_SERVERS);

  logic [31:0] busy_mem [MAX_SERVERS];
  logic [31:0] cnt_mem  [MAX_SERVERS];

  cfsa_state_t state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [IW-1:0] cursor_r, cursor_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] left_r, left_nxt;
  logic [31:0]   max_r, max_nxt;
  logic [31:0]   arr_r, svc_r;
  logic [31:0]   busy_q, cnt_q;
  logic [IW-1:0] rd_addr;
  logic          out_valid_r, out_valid_nxt;
  cfsa_out_t     out_r, out_nxt;
  logic          cfg_wr;
  logic [CFG_BITS-1:0] wv;
  logic [NW-1:0] wn;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [31:0]   mem_wb, mem_wc;
  logic [32:0]   sum;
  logic [31:0]   cinc;
  logic [IW-1:0] idx_inc;

  assign pready = 1'b1;
  assign prdata = 32'(n_r);
  assign cfg_wr = psel & penable & pwrite & (paddr == REG_ACTIVE_SERVERS);
  assign wv = pwdata[CFG_BITS-1:0];
  always_comb begin
    if (wv == '0) wn = NW'(1);
    else if (32'(wv) > 32'(MAX_SERVERS)) wn = NMAX;
    else wn = NW'(wv);
  end

  assign in_busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_r;
  assign sum = {1'b0, arr_r} + {1'b0, svc_r};
  assign cinc = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
  assign idx_inc = (NW'(idx_r) + NW'(1) >= n_r) ? '0 : idx_r + IW'(1);
  assign rd_addr = idx_r;

  always_ff @(posedge clk) begin
    busy_q <= busy_mem[rd_addr];
    cnt_q  <= cnt_mem[rd_addr];
    if (mem_we) begin
      busy_mem[mem_wa] <= mem_wb;
      cnt_mem[mem_wa]  <= mem_wc;
    end
    arr_r <= (state_r == ST_IDLE) ? in_word.arrival_time : arr_r;
    svc_r <= (state_r == ST_IDLE) ? in_word.service_time : svc_r;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (NW'(idx_r) == NMAX - NW'(1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_start) state_nxt = ST_WAIT;
      ST_WAIT:   state_nxt = ST_SCAN;
      ST_SCAN:   if (busy_q <= arr_r) state_nxt = ST_UPDATE;
                 else if (left_r == NW'(1)) state_nxt = ST_IDLE;
                 else state_nxt = ST_WAIT;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) state_nxt = ST_CLEAR;
  end

  always_comb begin
    n_nxt = n_r;
    cursor_nxt = cursor_r;
    idx_nxt = idx_r;
    left_nxt = left_r;
    max_nxt = max_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wb = '0;
    mem_wc = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        idx_nxt = (NW'(idx_r) == NMAX - NW'(1)) ? '0 : idx_r + IW'(1);
      end
      ST_IDLE: begin
        if (in_start) begin
          idx_nxt = cursor_r;
          left_nxt = n_r;
          cursor_nxt = (NW'(cursor_r) + NW'(1) >= n_r) ? '0 : cursor_r + IW'(1);
        end
      end
      ST_SCAN: begin
        if (busy_q <= arr_r) begin
        end else begin
          left_nxt = left_r - NW'(1);
          idx_nxt = idx_inc;
          if (left_r == NW'(1)) begin
            out_valid_nxt = 1'b1;
            out_nxt.dropped = 1'b1;
            out_nxt.server = '0;
            out_nxt.server_count = '0;
            out_nxt.max_count = max_r;
          end
        end
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
        mem_wb = sum[32] ? '1 : sum[31:0];
        mem_wc = cinc;
        if (cinc > max_r) max_nxt = cinc;
        out_valid_nxt = 1'b1;
        out_nxt.dropped = 1'b0;
        out_nxt.server = 10'(idx_r);
        out_nxt.server_count = cinc;
        out_nxt.max_count = (cinc > max_r) ? cinc : max_r;
      end
      default: ;
    endcase
    if (cfg_wr) begin
      n_nxt = wn;
      idx_nxt = '0;
      cursor_nxt = '0;
      max_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      n_r <= NMAX;
      cursor_r <= '0;
      idx_r <= '0;
      left_r <= '0;
      max_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      cursor_r <= cursor_nxt;
      idx_r <= idx_nxt;
      left_r <= left_nxt;
      max_r <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

FILE: rtl/core/cfsa_checker.sv
// cfsa_checker: port-level checks for cyclic_free_server_allocator.
// Depends on cfsa_pkg; bound to the top level below.
module cfsa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_start,
  input logic                in_busy,
  input logic                out_valid,
  input cfsa_pkg::cfsa_out_t out_word
);
  import cfsa_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_start && !in_busy |=> in_busy) else $error("no busy after accept");
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.dropped |-> out_word.server_count == '0)
    else $error("dropped word carries a count");
  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.dropped |-> out_word.max_count >= out_word.server_count)
    else $error("max below count");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.dropped |-> out_word.server_count != '0)
    else $error("zero count on assignment");
endmodule

bind cyclic_free_server_allocator cfsa_checker u_cfsa_checker (
  .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
  .out_valid(out_valid), .out_word(out_word)
);

FILE: tb/sv/cyclic_free_server_allocator_tb.sv
// cyclic_free_server_allocator_tb: self-checking bench for the round-robin server allocator.
// Keeps its own model of the servers and checks each result word against it.
// Depends on cfsa_pkg and cyclic_free_server_allocator.
module cyclic_free_server_allocator_tb;
  import cfsa_pkg::*;

  localparam int NSRV = 1024;
  localparam longint LIMIT = 4000000;

  logic clk;
  logic rst_n;
  logic in_start;
  logic in_busy;
  cfsa_in_t in_word;
  logic out_valid;
  cfsa_out_t out_word;
  logic psel;
  logic penable;
  logic pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cyclic_free_server_allocator #(.MAX_SERVERS(NSRV)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_start(in_start), .in_busy(in_busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // server model
  logic [31:0] busy_until [NSRV];
  logic [31:0] req_cnt [NSRV];
  int unsigned n_active;
  int unsigned rr_ptr;
  logic [31:0] peak_cnt;

  cfsa_in_t request_q[$];
  cfsa_out_t grant_q[$];
  int unsigned idle_pct;
  int errors;
  int n_sent;
  int n_dropped;
  int n_cfg;
  longint cycles;
  logic [31:0] now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("cyclic_free_server_allocator regression: fail");
      $finish;
    end
  end

  task automatic clear_model(input int unsigned n);
    for (int i = 0; i < NSRV; i++) begin
      busy_until[i] = '0;
      req_cnt[i] = '0;
    end
    n_active = n;
    rr_ptr = 0;
    peak_cnt = '0;
  endtask

  function automatic cfsa_out_t predict_grant(input cfsa_in_t w);
    cfsa_out_t r;
    int unsigned s;
    logic [32:0] t;
    bit hit;
    hit = 1'b0;
    s = 0;
    r = '0;
    for (int k = 0; k < n_active; k++) begin
      s = (rr_ptr + k) % n_active;
      if (busy_until[s] <= w.arrival_time) begin
        hit = 1'b1;
        break;
      end
    end
    if (hit) begin
      t = {1'b0, w.arrival_time} + {1'b0, w.service_time};
      busy_until[s] = t[32] ? 32'hFFFF_FFFF : t[31:0];
      if (req_cnt[s] != 32'hFFFF_FFFF) req_cnt[s] = req_cnt[s] + 1;
      if (req_cnt[s] > peak_cnt) peak_cnt = req_cnt[s];
      r.server = s[9:0];
      r.server_count = req_cnt[s];
    end else begin
      r.dropped = 1'b1;
    end
    r.max_count = peak_cnt;
    rr_ptr = (rr_ptr + 1) % n_active;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_start <= 1'b0;
      in_word <= '0;
    end else begin
      if (in_start && !in_busy) begin
        grant_q.push_back(predict_grant(in_word));
        void'(request_q.pop_front());
        n_sent++;
      end
      if (in_start && in_busy) begin
        in_start <= 1'b1;
      end else if (request_q.size() > (in_start ? 1 : 0) - (in_start ? 1 : 0)
                   && request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_start <= 1'b1;
        in_word <= request_q[0];
      end else begin
        in_start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (grant_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        cfsa_out_t e;
        e = grant_q.pop_front();
        if (e.dropped) n_dropped++;
        if (out_word.dropped !== e.dropped) begin
          $error("dropped: expected %0d actual %0d", e.dropped, out_word.dropped);
          errors++;
        end
        if (out_word.server !== e.server) begin
          $error("server: expected %0d actual %0d", e.server, out_word.server);
          errors++;
        end
        if (out_word.server_count !== e.server_count) begin
          $error("server_count: expected %0d actual %0d", e.server_count,
                 out_word.server_count);
          errors++;
        end
        if (out_word.max_count !== e.max_count) begin
          $error("max_count: expected %0d actual %0d", e.max_count, out_word.max_count);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (request_q.size() != 0 || grant_q.size() != 0 || in_start) @(posedge clk);
    repeat (NSRV + 16) @(posedge clk);
  endtask

  task automatic write_servers(input logic [31:0] v);
    int unsigned n;
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_ACTIVE_SERVERS;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n = v[10:0];
    if (n == 0) n = 1;
    if (n > NSRV) n = NSRV;
    clear_model(n);
    now = '0;
    n_cfg++;
  endtask

  task automatic push_req(input logic [31:0] a, input logic [31:0] s);
    cfsa_in_t w;
    w.arrival_time = a;
    w.service_time = s;
    request_q.push_back(w);
  endtask

  task automatic random_reqs(input int count, input int unsigned pct);
    logic [31:0] svc;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0: push_req(now - $urandom_range(5), $urandom);
        1: push_req(now, $urandom);
        2: begin
          now = $urandom;
          push_req(now, $urandom_range(8));
        end
        default: begin
          now = now + $urandom_range(3);
          svc = $urandom_range(3 * n_active + 4);
          push_req(now, svc);
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_start = 1'b0;
    in_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    errors = 0;
    n_sent = 0;
    n_dropped = 0;
    n_cfg = 0;
    cycles = 0;
    now = '0;
    clear_model(NSRV);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset-default server count, then narrow pools for drops and saturation
    push_req(32'h0, 32'h0);
    push_req(32'h0, 32'hFFFF_FFFF);
    push_req(32'h5, 32'h10);
    write_servers(32'd0);
    push_req(32'h0, 32'h3);
    push_req(32'h1, 32'h1);
    push_req(32'h3, 32'h0);
    push_req(32'h3, 32'h0);
    push_req(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    push_req(32'hFFFF_FFFF, 32'h0);
    write_servers(32'd3);
    push_req(32'h10, 32'h100);
    push_req(32'h10, 32'h100);
    push_req(32'h10, 32'h100);
    push_req(32'h11, 32'h1);
    push_req(32'h8, 32'h1);
    push_req(32'h110, 32'h0);
    push_req(32'h110, 32'h0);
    write_servers(32'h7FF);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(32'hAAAA_AAAA, 32'h5555_5555);
    push_req(32'h5555_5555, 32'hAAAA_AAAA);

    write_servers(32'd4);
    random_reqs(100, 0);
    write_servers(32'd1);
    random_reqs(60, 49);
    write_servers(32'd17);
    random_reqs(100, 26);
    write_servers(32'd1024);
    random_reqs(40, 49);
    write_servers(32'd2);
    random_reqs(80, 0);
    write_servers($urandom_range(5, 300));
    random_reqs(100, 26);
    wait_drained();

    $display("%0d requests over %0d server-count settings, %0d dropped",
             n_sent, n_cfg, n_dropped);
    if (errors == 0) begin
      $display("cyclic_free_server_allocator regression: pass");
    end else begin
      $display("cyclic_free_server_allocator regression: fail");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/cfsa_pkg.sv
rtl/core/cyclic_free_server_allocator.sv
rtl/core/cfsa_checker.sv
tb/sv/cyclic_free_server_allocator_tb.sv
